// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behavior.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timer scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timer scheduler assertion failed");

`endif

// ===== rtl/mts_pkg.sv =====
// Shared constants, codes and control/status types of the timer scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int unsigned DEF_NUM_TIMERS = 16;
    localparam int unsigned DEF_TIME_WIDTH = 48;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned VAL_W   = 31;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned MAX_FIRE = 16;
    localparam int unsigned CNT_W   = $clog2(MAX_FIRE + 1);

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INVAL = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOUSE = 2'd3;

    localparam logic [1:0] MODE_FREE    = 2'd0;
    localparam logic [1:0] MODE_ARMED   = 2'd1;
    localparam logic [1:0] MODE_PENDING = 2'd2;
    localparam logic [1:0] MODE_STOPPED = 2'd3;

    // Kind of the latched request, as seen by the controller.
    typedef enum logic [1:0] {
        K_ADD  = 2'd0,
        K_SLOT = 2'd1,
        K_TICK = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic accept;
        logic idx_clr;
        logic tick_start;
        logic idx_inc;
        logic add_wr;
        logic slot_do;
        logic arm;
        logic eval;
        logic resp;
    } t_ctl;

    typedef struct packed {
        t_kind kind;
        logic  idx_last;
        logic  idx_free;
        logic  eval_block;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/mts_ctrl.sv =====
// Controller state machine of the timer scheduler.
// Depends on mts_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DISP = 9'b000000010,
        S_FIND = 9'b000000100,
        S_READ = 9'b000001000,
        S_DO   = 9'b000010000,
        S_RD   = 9'b000100000,
        S_ARM  = 9'b001000000,
        S_EVAL = 9'b010000000,
        S_RESP = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.kind)
                    K_ADD: begin
                        o_ctl.idx_clr = 1'b1;
                        n_state = S_FIND;
                    end
                    K_SLOT: n_state = S_READ;
                    K_TICK: begin
                        o_ctl.tick_start = 1'b1;
                        n_state = S_RD;
                    end
                    default: n_state = S_RESP;
                endcase
            end
            S_FIND: begin
                if (i_sts.idx_free) begin
                    o_ctl.add_wr = 1'b1;
                    n_state = S_RESP;
                end else if (i_sts.idx_last) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                end
            end
            S_READ: n_state = S_DO;
            S_DO: begin
                o_ctl.slot_do = 1'b1;
                n_state = S_RESP;
            end
            S_RD: n_state = S_ARM;
            S_ARM: begin
                o_ctl.arm = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!i_sts.eval_block) begin
                    o_ctl.eval = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_RESP;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_ctl.resp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/mts_datapath.sv =====
// Datapath of the timer scheduler: timer table memories, clock, scan
// arithmetic and the output register. Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_datapath
    import mts_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    output t_sts              o_sts,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [VAL_W-1:0]  i_first_delay,
    input  logic [VAL_W-1:0]  i_repeat_period,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [ST_W-1:0]   o_status,
    output logic [SLOT_W-1:0] o_timer_id,
    output logic [VAL_W-1:0]  o_value,
    output logic              o_fired,
    output logic              o_has_next,
    output logic [VAL_W-1:0]  o_time_to_next,
    output logic              o_last
);

    localparam int unsigned IDX_W = $clog2(NUM_TIMERS);
    localparam int unsigned TW    = TIME_WIDTH;

    logic [CMD_W-1:0]  r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [VAL_W-1:0]  r_fd, r_rp;
    logic [IDX_W-1:0]  r_idx;
    logic [TW-1:0]     r_time;
    logic [1:0]        r_mode [NUM_TIMERS];

    logic [TW-1:0]     mem_exp  [NUM_TIMERS];
    logic [VAL_W-1:0]  mem_per  [NUM_TIMERS];
    logic [VAL_W-1:0]  mem_pend [NUM_TIMERS];
    logic [TW-1:0]     r_rd_exp;
    logic [VAL_W-1:0]  r_rd_per, r_rd_pend;

    logic [TW-1:0]     r_exp_arm, r_reload;
    logic              r_armed;
    logic [CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]  r_best;
    logic              r_hn;
    logic              r_hold_v;
    logic [SLOT_W-1:0] r_hold_id;
    logic [VAL_W-1:0]  r_hold_iv;
    logic              r_found, r_used;

    logic              r_out_v;
    logic [ST_W-1:0]   r_o_status;
    logic [SLOT_W-1:0] r_o_id;
    logic [VAL_W-1:0]  r_o_value, r_o_ttn;
    logic              r_o_fired, r_o_hn, r_o_last;

    logic [1:0]        cur_mode;
    logic [VAL_W-1:0]  iv, rem_clip, cand;
    logic [TW-1:0]     rem;
    logic              expired, fire, still, out_free, used, in_range, push;
    t_kind             kind;
    logic [ST_W-1:0]   f_status;
    logic [SLOT_W-1:0] f_id;
    logic [VAL_W-1:0]  f_value, f_ttn;
    logic              f_fired;

    assign cur_mode = r_mode[r_idx];
    assign iv       = (r_rd_pend != '0) ? r_rd_pend : r_rd_per;
    assign rem      = r_exp_arm - r_time;
    assign expired  = (rem == '0) || rem[TW-1];
    assign fire     = r_armed && expired && (r_cnt < CNT_W'(MAX_FIRE));
    assign still    = fire ? (r_rd_per != '0) : r_armed;
    assign out_free = !r_out_v || !i_stall;
    assign push     = i_ctl.eval && fire && r_hold_v;
    assign in_range = 32'(r_slot) < 32'(NUM_TIMERS);
    assign used     = in_range && (cur_mode != MODE_FREE);

    always_comb begin
        if (expired) begin
            rem_clip = VAL_W'(1);
        end else if (|rem[TW-1:VAL_W]) begin
            rem_clip = VAL_MAX;
        end else begin
            rem_clip = rem[VAL_W-1:0];
        end
        cand = fire ? r_rd_per : rem_clip;
    end

    always_comb begin
        case (r_cmd)
            CMD_ADD:                   kind = ((r_fd == '0) && (r_rp == '0)) ? K_DONE : K_ADD;
            CMD_SET, CMD_DEL, CMD_GET: kind = K_SLOT;
            CMD_TICK:                  kind = K_TICK;
            default:                   kind = K_DONE;
        endcase
    end

    assign o_sts.kind       = kind;
    assign o_sts.idx_last   = (r_idx == IDX_W'(NUM_TIMERS - 1));
    assign o_sts.idx_free   = (cur_mode == MODE_FREE);
    assign o_sts.eval_block = fire && r_hold_v && !out_free;
    assign o_sts.out_free   = out_free;

    // Final result of the current request.
    always_comb begin
        f_status = ST_OK;
        f_id     = '0;
        f_value  = '0;
        f_fired  = 1'b0;
        f_ttn    = '0;
        case (r_cmd)
            CMD_TICK: begin
                if (r_hold_v) begin
                    f_id    = r_hold_id;
                    f_value = r_hold_iv;
                    f_fired = 1'b1;
                end
                f_ttn = r_hn ? r_best : '0;
            end
            CMD_ADD: begin
                if (kind == K_DONE) begin
                    f_status = ST_INVAL;
                end else if (r_found) begin
                    f_id = SLOT_W'(r_idx);
                end else begin
                    f_status = ST_FULL;
                end
            end
            CMD_SET, CMD_DEL, CMD_GET: begin
                f_id = r_slot;
                if (!r_used) begin
                    f_status = ST_NOUSE;
                end else if (r_cmd == CMD_GET) begin
                    f_value = iv;
                end
            end
            default: f_status = ST_INVAL;
        endcase
    end

    // Table memories: one address per cycle, registered read.
    always_ff @(posedge i_clk) begin
        r_rd_exp  <= mem_exp[r_idx];
        r_rd_per  <= mem_per[r_idx];
        r_rd_pend <= mem_pend[r_idx];
        if (i_ctl.add_wr) begin
            mem_exp[r_idx]  <= '0;
            mem_per[r_idx]  <= r_rp;
            mem_pend[r_idx] <= r_fd;
        end
        if (i_ctl.slot_do && used && (r_cmd == CMD_SET)) begin
            mem_pend[r_idx] <= r_fd;
        end
        if (i_ctl.eval && r_armed) begin
            mem_exp[r_idx] <= fire ? r_reload : r_exp_arm;
            if (fire) begin
                mem_pend[r_idx] <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd  <= i_cmd;
            r_slot <= i_slot;
            r_fd   <= i_first_delay;
            r_rp   <= i_repeat_period;
        end
        if (i_ctl.arm) begin
            r_reload <= r_time + TW'(r_rd_per);
            if (cur_mode == MODE_PENDING) begin
                r_exp_arm <= r_time + TW'(iv);
            end else begin
                r_exp_arm <= r_rd_exp;
            end
        end
        if (i_ctl.eval && fire) begin
            r_hold_id <= SLOT_W'(r_idx);
            r_hold_iv <= iv;
        end
        if (push) begin
            r_o_status <= ST_OK;
            r_o_id     <= r_hold_id;
            r_o_value  <= r_hold_iv;
            r_o_fired  <= 1'b1;
            r_o_hn     <= 1'b0;
            r_o_ttn    <= '0;
            r_o_last   <= 1'b0;
        end else if (i_ctl.resp) begin
            r_o_status <= f_status;
            r_o_id     <= f_id;
            r_o_value  <= f_value;
            r_o_fired  <= f_fired;
            r_o_hn     <= (r_cmd == CMD_TICK) && r_hn;
            r_o_ttn    <= f_ttn;
            r_o_last   <= 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_time   <= '0;
            r_armed  <= 1'b0;
            r_cnt    <= '0;
            r_best   <= VAL_MAX;
            r_hn     <= 1'b0;
            r_hold_v <= 1'b0;
            r_found  <= 1'b0;
            r_used   <= 1'b0;
            r_out_v  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_mode[i] <= MODE_FREE;
            end
        end else begin
            if (i_ctl.accept) begin
                r_idx   <= IDX_W'(i_slot);
                r_found <= 1'b0;
                r_used  <= 1'b0;
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end
            if (i_ctl.tick_start) begin
                r_idx    <= '0;
                r_time   <= r_time + TW'(1);
                r_cnt    <= '0;
                r_best   <= VAL_MAX;
                r_hn     <= 1'b0;
                r_hold_v <= 1'b0;
            end
            if (i_ctl.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_ctl.add_wr) begin
                r_mode[r_idx] <= MODE_PENDING;
                r_found       <= 1'b1;
            end
            if (i_ctl.slot_do) begin
                r_used <= used;
                if (used && (r_cmd == CMD_SET)) begin
                    r_mode[r_idx] <= MODE_PENDING;
                end else if (used && (r_cmd == CMD_DEL)) begin
                    r_mode[r_idx] <= MODE_FREE;
                end
            end
            if (i_ctl.arm) begin
                r_armed <= (cur_mode == MODE_PENDING) || (cur_mode == MODE_ARMED);
            end
            if (i_ctl.eval) begin
                if (r_armed) begin
                    r_mode[r_idx] <= still ? MODE_ARMED : MODE_STOPPED;
                end
                if (fire) begin
                    r_hold_v <= 1'b1;
                    r_cnt    <= r_cnt + CNT_W'(1);
                end
                if (still) begin
                    r_hn <= 1'b1;
                    if (cand < r_best) begin
                        r_best <= cand;
                    end
                end
            end
            if (push || i_ctl.resp) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_v;
    assign o_status       = r_o_status;
    assign o_timer_id     = r_o_id;
    assign o_value        = r_o_value;
    assign o_fired        = r_o_fired;
    assign o_has_next     = r_o_hn;
    assign o_time_to_next = r_o_ttn;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/multi_timer_scheduler_core.sv =====
// Top level of the multi-channel timer scheduler: controller plus datapath.
// Depends on mts_pkg, mts_ctrl, mts_datapath and assert_macros.svh.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+------------------------------------
//   request  | in        | i_valid / o_stall  | i_cmd i_slot i_first_delay
//            |           |                    | i_repeat_period
//   result   | out       | o_valid / i_stall  | o_status o_timer_id o_value o_fired
//            |           |                    | o_has_next o_time_to_next o_last
//
// An add searches the slots in order from slot 0 for a free one.
// Set, delete and get read the addressed slot and then act on it. A tick scans
// every slot in turn through the single-port timer table (read, arm, evaluate).
// A stalled result holds the scan only when a further timer fires.
// Reset is synchronous and active low; it frees every slot and clears the clock.
// o_stall is high while a request is being worked on.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module multi_timer_scheduler_core
    import mts_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [VAL_W-1:0]  i_first_delay,
    input  logic [VAL_W-1:0]  i_repeat_period,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [SLOT_W-1:0] o_timer_id,
    output logic [VAL_W-1:0]  o_value,
    output logic              o_fired,
    output logic              o_has_next,
    output logic [VAL_W-1:0]  o_time_to_next,
    output logic              o_last
);

    t_ctl ctl;
    t_sts sts;

    // The controller sequences each request; it only sees decoded status.
    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (o_stall)
    );

    // The datapath holds the timer table, the microsecond clock and the
    // result register, which lets a finished result wait while the next
    // request is taken.
    mts_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cmd           (i_cmd),
        .i_slot          (i_slot),
        .i_first_delay   (i_first_delay),
        .i_repeat_period (i_repeat_period),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_timer_id      (o_timer_id),
        .o_value         (o_value),
        .o_fired         (o_fired),
        .o_has_next      (o_has_next),
        .o_time_to_next  (o_time_to_next),
        .o_last          (o_last)
    );

    // A fired timer is always reported with an ok status.
    `MTS_ASSERT_IMP(a_fired_ok, i_clk, i_rst_n, o_valid && o_fired, o_status == ST_OK)
    // The next-expiry summary rides only on a final result and is never zero.
    `MTS_ASSERT_IMP(a_next_last, i_clk, i_rst_n, o_valid && o_has_next, o_last && (o_time_to_next != '0))
    // Only tick firings produce results that are not the last of a request.
    `MTS_ASSERT_IMP(a_mid_fired, i_clk, i_rst_n, o_valid && !o_last, o_fired)
    // Once a request is taken the block reports busy in the following cycle.
    `MTS_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

`default_nettype wire
